/* rtl/hcbd_pkg.sv */
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // width of the chunk size counter
    localparam int SIZE_BITS  = 64;
    localparam int DIGIT_BITS = 4;   // one hex digit

    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_SP    = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_DIG0  = 8'h30;
    localparam logic [7:0] CHR_DIG9  = 8'h39;
    localparam logic [7:0] CHR_LOW_A = 8'h61;
    localparam logic [7:0] CHR_LOW_F = 8'h66;
    localparam logic [7:0] CHR_UP_A  = 8'h41;
    localparam logic [7:0] CHR_UP_F  = 8'h46;
    localparam logic [7:0] HEX_TEN   = 8'd10;

    typedef enum logic [1:0] {
        STATUS_BUSY     = 2'd0,
        STATUS_DONE     = 2'd1,
        STATUS_ERR_SIZE = 2'd2,
        STATUS_ERR_TERM = 2'd3
    } status_t;

    typedef enum logic [10:0] {
        PH_LEAD    = 11'b000_0000_0001,
        PH_DIGITS  = 11'b000_0000_0010,
        PH_EXT     = 11'b000_0000_0100,
        PH_DATA    = 11'b000_0000_1000,
        PH_DCR     = 11'b000_0001_0000,
        PH_DLF     = 11'b000_0010_0000,
        PH_TSTART  = 11'b000_0100_0000,
        PH_TLINE   = 11'b000_1000_0000,
        PH_DONE    = 11'b001_0000_0000,
        PH_ERRSIZE = 11'b010_0000_0000,
        PH_ERRTERM = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       start_of_body;
    } in_item_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [1:0] decode_status;
    } out_item_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic                  start;
        logic [7:0]            data;
        logic                  is_cr;
        logic                  is_lf;
        logic                  is_blank;
        logic                  is_hex;
        logic [DIGIT_BITS-1:0] hex_val;
    } class_t;

endpackage

/* rtl/hcbd_front.sv */
// ----------------------------------------------------------------------------
// hcbd_front
// Accepts raw body bytes and tags them (CR, LF, blank, hex digit value).
// ----------------------------------------------------------------------------
module hcbd_front (
    input  logic               body_valid,
    output logic               body_ready,
    input  hcbd_pkg::in_item_t body,
    output logic               enq_valid,
    input  logic               enq_ready,
    output hcbd_pkg::class_t   enq_item
);
    import hcbd_pkg::*;

    logic [7:0] b;
    logic       is_dec;
    logic       is_low;
    logic       is_up;
    logic [7:0] low_val;
    logic [7:0] up_val;
    logic [7:0] dec_val;

    assign b       = body.body_byte;
    assign is_dec  = (b >= CHR_DIG0) && (b <= CHR_DIG9);
    assign is_low  = (b >= CHR_LOW_A) && (b <= CHR_LOW_F);
    assign is_up   = (b >= CHR_UP_A) && (b <= CHR_UP_F);
    assign dec_val = b - CHR_DIG0;
    assign low_val = b - CHR_LOW_A + HEX_TEN;
    assign up_val  = b - CHR_UP_A + HEX_TEN;

    always_comb
    begin
        enq_item.start    = body.start_of_body;
        enq_item.data     = b;
        enq_item.is_cr    = (b == CHR_CR);
        enq_item.is_lf    = (b == CHR_LF);
        enq_item.is_blank = (b == CHR_SP) || (b == CHR_TAB);
        enq_item.is_hex   = is_dec || is_low || is_up;
        if (is_dec)
        begin
            enq_item.hex_val = dec_val[DIGIT_BITS-1:0];
        end
        else if (is_low)
        begin
            enq_item.hex_val = low_val[DIGIT_BITS-1:0];
        end
        else
        begin
            enq_item.hex_val = up_val[DIGIT_BITS-1:0];
        end
    end

    assign enq_valid  = body_valid;
    assign body_ready = enq_ready;

endmodule

/* rtl/hcbd_queue.sv */
// ----------------------------------------------------------------------------
// hcbd_queue
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module hcbd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enq_valid,
    output logic             enq_ready,
    input  hcbd_pkg::class_t enq_item,
    output logic             deq_valid,
    input  logic             deq_ready,
    output hcbd_pkg::class_t deq_item
);
    import hcbd_pkg::*;

    class_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign enq_ready = (count_reg != 2'd2);
    assign deq_valid = (count_reg != 2'd0);
    assign deq_item  = entry_reg[rd_ptr_reg];
    assign push      = enq_valid && enq_ready;
    assign pop       = deq_valid && deq_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= enq_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

/* rtl/hcbd_back.sv */
// ----------------------------------------------------------------------------
// hcbd_back
// Chunk parser: size line, data pass-through, terminator and trailer checks.
// One classified byte per cycle, when not stalled, into a registered result slot.
// ----------------------------------------------------------------------------
module hcbd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                deq_valid,
    output logic                deq_ready,
    input  hcbd_pkg::class_t    deq_item,
    output logic                result_valid,
    input  logic                result_ready,
    output hcbd_pkg::out_item_t result
);
    import hcbd_pkg::*;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic                  pcr_reg;
    logic                  pcr_next;
    logic [SIZE_BITS-1:0]  rem_reg;
    logic [SIZE_BITS-1:0]  rem_next;
    logic                  ds_reg;
    logic                  ds_next;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;
    out_item_t             out_item_next;
    logic                  advance;
    logic                  step;
    logic                  acc;
    status_t               status;

    assign advance   = !out_valid_reg || result_ready;
    assign deq_ready = advance;
    assign step      = deq_valid && advance;

    always_comb
    begin
        phase_next = phase_reg;
        pcr_next   = pcr_reg;
        rem_next   = rem_reg;
        ds_next    = ds_reg;
        acc        = 1'b0;
        out_item_next.payload_valid = 1'b0;
        out_item_next.payload_byte  = 8'd0;

        if (deq_item.start)
        begin
            phase_next = PH_LEAD;
            pcr_next   = 1'b0;
            rem_next   = '0;
            ds_next    = 1'b0;
        end

        case (phase_next)
            PH_LEAD, PH_DIGITS, PH_EXT:
            begin
                if (pcr_next)
                begin
                    pcr_next = 1'b0;
                    if (deq_item.is_lf)
                    begin
                        // end of size line
                        if (!ds_next)
                        begin
                            phase_next = PH_ERRSIZE;
                        end
                        else
                        begin
                            phase_next = (rem_next == '0) ? PH_TSTART : PH_DATA;
                            ds_next    = 1'b0;
                        end
                    end
                    else if (phase_next == PH_LEAD)
                    begin
                        phase_next = PH_ERRSIZE;
                    end
                    else
                    begin
                        // stray CR is an extension char; this byte then falls in EXT
                        phase_next = PH_EXT;
                        pcr_next   = deq_item.is_cr;
                    end
                end
                else if (deq_item.is_cr)
                begin
                    pcr_next = 1'b1;
                end
                else
                begin
                    case (phase_next)
                        PH_LEAD:
                        begin
                            if (!deq_item.is_blank)
                            begin
                                if (deq_item.is_hex)
                                begin
                                    phase_next = PH_DIGITS;
                                    acc        = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_ERRSIZE;
                                end
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (deq_item.is_hex)
                            begin
                                acc = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_EXT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (acc)
                    begin
                        if (rem_next[SIZE_BITS-1 -: DIGIT_BITS] != '0)
                        begin
                            phase_next = PH_ERRSIZE;
                        end
                        else
                        begin
                            rem_next = {rem_next[SIZE_BITS-DIGIT_BITS-1:0], deq_item.hex_val};
                            ds_next  = 1'b1;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                out_item_next.payload_valid = 1'b1;
                out_item_next.payload_byte  = deq_item.data;
                rem_next = rem_next - SIZE_BITS'(1);
                if (rem_next == '0)
                begin
                    phase_next = PH_DCR;
                end
            end
            PH_DCR:
            begin
                phase_next = deq_item.is_cr ? PH_DLF : PH_ERRTERM;
            end
            PH_DLF:
            begin
                if (deq_item.is_lf)
                begin
                    phase_next = PH_LEAD;
                    rem_next   = '0;
                    ds_next    = 1'b0;
                end
                else
                begin
                    phase_next = PH_ERRTERM;
                end
            end
            PH_TSTART:
            begin
                if (pcr_next)
                begin
                    if (deq_item.is_lf)
                    begin
                        pcr_next   = 1'b0;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_TLINE;
                        pcr_next   = deq_item.is_cr;
                    end
                end
                else if (deq_item.is_cr)
                begin
                    pcr_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_TLINE;
                end
            end
            PH_TLINE:
            begin
                if (pcr_next && deq_item.is_lf)
                begin
                    pcr_next   = 1'b0;
                    phase_next = PH_TSTART;
                end
                else
                begin
                    pcr_next = deq_item.is_cr;
                end
            end
            default:
            begin
                // done and error phases hold until the next start of body
            end
        endcase

        case (phase_next)
            PH_DONE:    status = STATUS_DONE;
            PH_ERRSIZE: status = STATUS_ERR_SIZE;
            PH_ERRTERM: status = STATUS_ERR_TERM;
            default:    status = STATUS_BUSY;
        endcase
        out_item_next.decode_status = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            pcr_reg       <= 1'b0;
            rem_reg       <= '0;
            ds_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                pcr_reg   <= pcr_next;
                rem_reg   <= rem_next;
                ds_reg    <= ds_next;
            end
            if (advance)
            begin
                out_valid_reg <= deq_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

`ifndef NO_ASSERTIONS
    a_data_in_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.payload_valid) |-> (result.decode_status == STATUS_BUSY))
        else $error("data byte delivered with final status");

    a_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.payload_valid) |-> (result.payload_byte == 8'd0))
        else $error("payload byte not cleared");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !deq_item.start && phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("completion not held");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (rem_reg != '0))
        else $error("data phase with empty count");
`endif

endmodule

/* rtl/http_chunked_body_decoder_core.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Decodes an HTTP/1.1 chunked body into payload bytes with a status per byte.
// ----------------------------------------------------------------------------
// Usage:
//   body channel: one raw body byte per request (body_valid/body_ready);
//     start_of_body clears the decoder before that byte is parsed.
//   result channel: exactly one result per body byte, in order
//     (result_valid/result_ready): payload_valid/payload_byte carry a data
//     byte, decode_status gives busy, complete, bad size line or bad
//     terminator. Complete and error states hold until start_of_body.
//   Each byte is queued, then parsed into the registered result slot.
//   Throughput: one byte per cycle while the result slot is free or read; the
//     parser updates phase and size counter (one 64-bit shift or decrement).
//   A two-entry queue sits between the classifier and the parser, and the
//     result is held in an output register, so input keeps flowing while a
//     finished result waits; a stalled receiver fills the queue, then
//     body_ready drops.
//   Reset: asynchronous, active low; decoder waits for a size line, queue and
//     result slot empty.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                body_valid,
    output logic                body_ready,
    input  hcbd_pkg::in_item_t  body,
    output logic                result_valid,
    input  logic                result_ready,
    output hcbd_pkg::out_item_t result
);
    import hcbd_pkg::*;

    logic   enq_valid;
    logic   enq_ready;
    class_t enq_item;
    logic   deq_valid;
    logic   deq_ready;
    class_t deq_item;

    hcbd_front u_front (
        .body_valid (body_valid),
        .body_ready (body_ready),
        .body       (body),
        .enq_valid  (enq_valid),
        .enq_ready  (enq_ready),
        .enq_item   (enq_item)
    );

    hcbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq_valid (enq_valid),
        .enq_ready (enq_ready),
        .enq_item  (enq_item),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_item  (deq_item)
    );

    hcbd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .deq_valid    (deq_valid),
        .deq_ready    (deq_ready),
        .deq_item     (deq_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
